FILE: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file of the resp message framer
// no dependencies; the macros expand to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/rmf_pkg.sv
// types and constants of the resp message framer
// no dependencies
`default_nettype none
package rmf_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_SIMPLE,
		KIND_BULK,
		KIND_ARRAY
	} kind_t;

	typedef struct packed {
		logic protocol_error;
		logic message_done;
		logic item_done;
	} result_t;

endpackage
`default_nettype wire

FILE: hdl/rmf_core.sv
// framing state and per-byte next-state logic of the resp message framer
// depends on rmf_pkg
`default_nettype none
module rmf_core #(
	parameter int COUNT_BITS = rmf_pkg::COUNT_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step_en,
	input  wire  [7:0]           data_byte,
	output rmf_pkg::result_t     result
);

	localparam int AW = COUNT_BITS + 4;

	logic [COUNT_BITS-1:0] pending_q, pending_n;
	logic                  in_line_q, in_line_n;
	rmf_pkg::kind_t        kind_q, kind_n;
	logic                  cr_q, cr_n;
	logic [COUNT_BITS-1:0] acc_q, acc_n;
	logic                  neg_q, neg_n;
	logic                  body_q, body_n;

	logic [AW-1:0]         acc_x10;
	logic [COUNT_BITS:0]   total;
	logic                  is_digit;
	logic                  fin;
	logic                  err;

	assign is_digit = (data_byte >= rmf_pkg::CH_ZERO) && (data_byte <= rmf_pkg::CH_NINE);
	// acc * 10 + digit, overflow shows in the top four bits
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{COUNT_BITS{1'b0}}, data_byte[3:0]};
	assign total = {1'b0, pending_q} - (COUNT_BITS+1)'(1) + {1'b0, acc_q};

	always_comb begin
		pending_n = pending_q;
		in_line_n = in_line_q;
		kind_n    = kind_q;
		cr_n      = cr_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		body_n    = body_q;
		fin       = 1'b0;
		err       = 1'b0;
		result    = '0;
		if (!in_line_q) begin
			case (data_byte) inside
				rmf_pkg::CH_PLUS, rmf_pkg::CH_MINUS, rmf_pkg::CH_COLON: kind_n = rmf_pkg::KIND_SIMPLE;
				rmf_pkg::CH_DOLLAR: kind_n = rmf_pkg::KIND_BULK;
				rmf_pkg::CH_STAR:   kind_n = rmf_pkg::KIND_ARRAY;
				default:            err = 1'b1;
			endcase
			if (pending_q == '0) begin
				pending_n = COUNT_BITS'(1);
			end
			in_line_n = 1'b1;
			cr_n      = 1'b0;
			acc_n     = '0;
			neg_n     = 1'b0;
			body_n    = 1'b0;
		end else if (data_byte == rmf_pkg::CH_LF && cr_q) begin
			if (body_q || kind_q == rmf_pkg::KIND_SIMPLE) begin
				fin = 1'b1;
			end else if (kind_q == rmf_pkg::KIND_BULK) begin
				if (neg_q) begin
					fin = 1'b1;
				end else begin
					body_n = 1'b1;
					cr_n   = 1'b0;
				end
			end else if (neg_q || acc_q == '0) begin
				fin = 1'b1;
			end else if (total[COUNT_BITS]) begin
				err = 1'b1;
			end else begin
				// array header replaces itself by its count
				pending_n = total[COUNT_BITS-1:0];
				in_line_n = 1'b0;
				kind_n    = rmf_pkg::KIND_NONE;
				cr_n      = 1'b0;
				acc_n     = '0;
				neg_n     = 1'b0;
			end
		end else begin
			if (!body_q) begin
				if (data_byte == rmf_pkg::CH_MINUS
					&& (kind_q == rmf_pkg::KIND_BULK || kind_q == rmf_pkg::KIND_ARRAY)) begin
					neg_n = 1'b1;
				end else if (kind_q == rmf_pkg::KIND_ARRAY && is_digit) begin
					if (acc_x10[AW-1:COUNT_BITS] != '0) begin
						err = 1'b1;
					end else begin
						acc_n = acc_x10[COUNT_BITS-1:0];
					end
				end
			end
			cr_n = (data_byte == rmf_pkg::CH_CR);
		end

		if (fin) begin
			result.item_done = 1'b1;
			in_line_n = 1'b0;
			kind_n    = rmf_pkg::KIND_NONE;
			cr_n      = 1'b0;
			body_n    = 1'b0;
			acc_n     = '0;
			neg_n     = 1'b0;
			if (pending_q <= COUNT_BITS'(1)) begin
				pending_n = '0;
				result.message_done = 1'b1;
			end else begin
				pending_n = pending_q - COUNT_BITS'(1);
			end
		end

		if (err) begin
			result    = '0;
			result.protocol_error = 1'b1;
			pending_n = '0;
			in_line_n = 1'b0;
			kind_n    = rmf_pkg::KIND_NONE;
			cr_n      = 1'b0;
			acc_n     = '0;
			neg_n     = 1'b0;
			body_n    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			in_line_q <= 1'b0;
			kind_q    <= rmf_pkg::KIND_NONE;
			cr_q      <= 1'b0;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			body_q    <= 1'b0;
		end else if (step_en) begin
			pending_q <= pending_n;
			in_line_q <= in_line_n;
			kind_q    <= kind_n;
			cr_q      <= cr_n;
			acc_q     <= acc_n;
			neg_q     <= neg_n;
			body_q    <= body_n;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/resp_message_framer.sv
// top level of the resp message framer: input register, framing core, output register
// depends on rmf_pkg, rmf_core and assert_macros.svh
//
// usage:
//   s_* takes one stream byte per word; m_* gives one result word per byte,
//   in order, with the item-done, message-done and protocol-error flags.
//   a word is moved on a rising edge where tvalid and tready are both high.
// path: an accepted byte is held in the input register, then the framing step
//   writes its result to the output register, which drives m_tvalid.
// throughput: one byte per cycle while the output is not stalled; the framing
//   state is updated once per byte by the combinational step logic in rmf_core.
// stall: while m_tready is low the result holds; one more byte can wait in
//   the input register, then s_tready drops until the result is taken.
// reset: arst_n clears the valid flags of both registers and the framing state,
//   so the block expects the type byte of a new message.
// on a protocol error the flag is reported and the framing state restarts.
`default_nettype none
`include "assert_macros.svh"
module resp_message_framer #(
	parameter int COUNT_BITS = rmf_pkg::COUNT_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] data_byte
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata    // [0] item_done, [1] message_done, [2] protocol_error
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             valid_s2;
	rmf_pkg::result_t result_s2;
	rmf_pkg::result_t step_res;
	logic             advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	rmf_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.data_byte (data_s1),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b00000, result_s2.protocol_error, result_s2.message_done,
		result_s2.item_done};

	`ASSERT_IMPLIES(a_err_alone, clk, arst_n, m_tvalid && result_s2.protocol_error, !result_s2.item_done && !result_s2.message_done)
	`ASSERT_IMPLIES(a_msg_is_item, clk, arst_n, m_tvalid && result_s2.message_done, result_s2.item_done)
	`ASSERT_IMPLIES(a_full_blocks, clk, arst_n, valid_s1 && valid_s2 && !m_tready, !s_tready)

endmodule
`default_nettype wire
